>>> rtl/gsm_pkg.sv
`default_nettype none
package gsm_pkg;

  // Q0.16 golden ratio conjugate, and the half LSB used for rounding
  localparam logic [15:0] PHI_Q16   = 16'd40503;
  localparam logic [15:0] PHI_ROUND = 16'd32768;

  localparam int unsigned AbsTolW  = 31;
  localparam int unsigned RelTolW  = 16;
  localparam int unsigned IterW    = 10;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_ABS_TOL  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REL_TOL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER = 2'd2;

  localparam logic [AbsTolW-1:0] ABS_TOL_RST  = 31'd1;
  localparam logic [RelTolW-1:0] REL_TOL_RST  = 16'd7;
  localparam logic [IterW-1:0]   MAX_ITER_RST = 10'd100;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_VALUE = 1'b1;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_MAX_ITER = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_FIRST     = 3'd1,
    PH_SECOND    = 3'd2,
    PH_NEW_LEFT  = 3'd3,
    PH_NEW_RIGHT = 3'd4,
    PH_FINAL     = 3'd5
  } gsm_phase_e;

  typedef struct packed {
    logic              command;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic              want_value;
    logic signed [31:0] func_value;
  } gsm_req_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] point;
    logic signed [31:0] best_value;
    logic [1:0]        status;
    logic [IterW-1:0]  iterations;
  } gsm_res_t;

  // round(phi * w), w is a non-negative bracket width (33 bits)
  function automatic logic [31:0] phi_of(input logic [32:0] w);
    logic [48:0] prod;
    prod = {16'd0, w} * {33'd0, PHI_Q16} + {33'd0, PHI_ROUND};
    return prod[47:16];
  endfunction

endpackage
`default_nettype wire

>>> rtl/golden_section_minimizer.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   in_req_i  (gsm_req_t)
// result    out        out_valid_o / out_stall_i out_res_o (gsm_res_t)
// config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; each result is registered in the
// result or the skid register. Path: midpoint, tolerance multiply and width
// compare, in parallel with the phi multiplies for both candidate points, then the
// bracket update. A skid register behind the result register takes one more
// result while out_stall_i is high; in_stall_o rises only when both hold a result.
// Reset (async, active low) clears search state and valids, loads register defaults.
module golden_section_minimizer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gsm_pkg::gsm_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gsm_pkg::gsm_res_t      out_res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [gsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gsm_pkg::CfgDataW-1:0] cfg_data_i
);
  import gsm_pkg::*;

  // configuration
  logic [AbsTolW-1:0] abs_tol_q;
  logic [RelTolW-1:0] rel_tol_q;
  logic [IterW-1:0]   max_iter_q;

  // search state
  gsm_phase_e         phase_q, phase_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [31:0] il_q, il_d, ir_q, ir_d;     // interior points
  logic signed [31:0] lv_q, lv_d, rv_q, rv_d;     // values at interior points
  logic [31:0]        last_tol_q, last_tol_d;
  logic [IterW-1:0]   step_q, step_d;
  logic               final_q, final_d;

  // output register and skid
  logic     main_v_q, skid_v_q;
  gsm_res_t main_q, skid_q;

  logic     in_acc, out_fire;
  logic     res_v;
  gsm_res_t res;

  logic signed [31:0] fv, a_in, b_in;
  logic signed [32:0] width_cur, start_w, left_w, right_w;
  logic signed [32:0] mid_sum;
  logic signed [31:0] mid;
  logic [31:0]        amid;
  logic [47:0]        tol_prod;
  logic [31:0]        tol_now;
  logic signed [31:0] left_cand, right_cand;
  logic signed [31:0] lv_new, rv_new;
  logic               go_left, may_step, at_limit;
  logic [1:0]         end_status;

  assign fv   = in_req_i.func_value;
  assign a_in = in_req_i.lower;
  assign b_in = in_req_i.upper;

  assign in_stall_o  = skid_v_q;
  assign in_acc      = in_valid_i & ~skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;
  assign out_fire    = main_v_q & ~out_stall_i;

  // bracket arithmetic on the held state
  assign width_cur = {hi_q[31], hi_q} - {lo_q[31], lo_q};
  assign start_w   = {b_in[31], b_in} - {a_in[31], a_in};
  assign left_w    = {ir_q[31], ir_q} - {lo_q[31], lo_q};
  assign right_w   = {hi_q[31], hi_q} - {il_q[31], il_q};

  // candidate new interior points for either reduction, one multiply each
  assign left_cand  = ir_q - $signed(phi_of(left_w));
  assign right_cand = il_q + $signed(phi_of(right_w));

  // midpoint = floor((lo + hi) / 2) and tolerance abs + rel*|mid|, rel in Q0.16
  assign mid_sum  = {lo_q[31], lo_q} + {hi_q[31], hi_q};
  assign mid      = mid_sum[32:1];
  assign amid     = mid[31] ? (~mid + 32'd1) : mid;
  assign tol_prod = {16'd0, amid} * {32'd0, rel_tol_q};
  assign tol_now  = {1'b0, abs_tol_q} + tol_prod[47:16];

  assign may_step   = step_q < max_iter_q;
  assign at_limit   = (step_q >= max_iter_q) && (width_cur > $signed({1'b0, last_tol_q}));
  assign end_status = at_limit ? STATUS_MAX_ITER : STATUS_OK;

  // value just returned lands in the slot probed last
  assign lv_new  = (phase_q == PH_NEW_LEFT) ? fv : lv_q;
  assign rv_new  = (phase_q == PH_NEW_LEFT) ? rv_q : fv;
  assign go_left = lv_new < rv_new;

  always_comb begin
    phase_d    = phase_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    il_d       = il_q;
    ir_d       = ir_q;
    lv_d       = lv_q;
    rv_d       = rv_q;
    last_tol_d = last_tol_q;
    step_d     = step_q;
    final_d    = final_q;
    res_v      = 1'b0;
    res        = '0;

    if (in_acc) begin
      if (in_req_i.command == CMD_START) begin
        step_d     = '0;
        last_tol_d = '0;
        final_d    = in_req_i.want_value;
        res_v      = 1'b1;
        if (a_in >= b_in) begin
          // empty or reversed bracket: done at once, point stands for NaN
          phase_d    = PH_IDLE;
          res.kind   = KIND_DONE;
          res.status = STATUS_INVALID;
        end else begin
          lo_d      = a_in;
          hi_d      = b_in;
          il_d      = b_in - $signed(phi_of(start_w));
          ir_d      = a_in + $signed(phi_of(start_w));
          lv_d      = '0;
          rv_d      = '0;
          phase_d   = PH_FIRST;
          res.kind  = KIND_PROBE;
          res.point = il_d;
        end
      end else begin
        unique case (phase_q)
          PH_FIRST: begin
            lv_d      = fv;
            phase_d   = PH_SECOND;
            res_v     = 1'b1;
            res.kind  = KIND_PROBE;
            res.point = ir_q;
          end
          PH_SECOND, PH_NEW_LEFT, PH_NEW_RIGHT: begin
            lv_d  = lv_new;
            rv_d  = rv_new;
            res_v = 1'b1;
            if (may_step) begin
              last_tol_d = tol_now;
            end
            if (may_step && (width_cur > $signed({1'b0, tol_now}))) begin
              step_d   = step_q + IterW'(1);
              res.kind = KIND_PROBE;
              if (go_left) begin
                hi_d      = ir_q;
                ir_d      = il_q;
                rv_d      = lv_new;
                il_d      = left_cand;
                phase_d   = PH_NEW_LEFT;
                res.point = left_cand;
              end else begin
                lo_d      = il_q;
                il_d      = ir_q;
                lv_d      = rv_new;
                ir_d      = right_cand;
                phase_d   = PH_NEW_RIGHT;
                res.point = right_cand;
              end
            end else if (final_q) begin
              // one more probe at the answer for its value
              phase_d   = PH_FINAL;
              res.kind  = KIND_PROBE;
              res.point = mid;
            end else begin
              phase_d    = PH_IDLE;
              res.kind   = KIND_DONE;
              res.point  = mid;
              res.status = end_status;
            end
          end
          PH_FINAL: begin
            phase_d        = PH_IDLE;
            res_v          = 1'b1;
            res.kind       = KIND_DONE;
            res.point      = mid;
            res.best_value = fv;
            res.status     = end_status;
          end
          default: begin
            // value with no search running: dropped
          end
        endcase
      end
    end
    res.iterations = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q  <= ABS_TOL_RST;
      rel_tol_q  <= REL_TOL_RST;
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ABS_TOL:  abs_tol_q  <= cfg_data_i;
        CFG_REL_TOL:  rel_tol_q  <= cfg_data_i[RelTolW-1:0];
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[IterW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      lo_q       <= '0;
      hi_q       <= '0;
      il_q       <= '0;
      ir_q       <= '0;
      lv_q       <= '0;
      rv_q       <= '0;
      last_tol_q <= '0;
      step_q     <= '0;
      final_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      il_q       <= il_d;
      ir_q       <= ir_d;
      lv_q       <= lv_d;
      rv_q       <= rv_d;
      last_tol_q <= last_tol_d;
      step_q     <= step_d;
      final_q    <= final_d;
    end
  end

  // result register with skid; requests are refused only while skid is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_v) begin
      if (main_v_q && !out_fire) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        main_q <= skid_q;
      end
    end else if (res_v) begin
      if (main_v_q && !out_fire) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsm_pkg::*;

  localparam int unsigned RandItems  = 1450;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 8;
  localparam int          QMin       = int'(32'h8000_0000);
  localparam int          QMax       = int'(32'h7fff_ffff);
  localparam longint      PhiQ16     = 40503;

  // Clock, reset and DUT ports; every input is known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gsm_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gsm_res_t out_res_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  golden_section_minimizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Search predictor: shadow registers and bracket state
  // ---------------------------------------------------------------------
  logic [AbsTolW-1:0] cur_abs_tol  = ABS_TOL_RST;
  logic [RelTolW-1:0] cur_rel_tol  = REL_TOL_RST;
  logic [IterW-1:0]   cur_max_iter = MAX_ITER_RST;

  longint     br_lo, br_hi;     // bracket ends
  longint     pt_c, pt_d;       // left / right interior points
  longint     f_c, f_d;         // f at the interior points
  longint     tol_last;         // tolerance of the last width test
  logic [IterW-1:0] iter_cnt;
  gsm_phase_e ph = PH_IDLE;
  logic       want_final;

  gsm_res_t expected_results[$];
  logic signed [31:0] last_probe = '0;  // last point the block asked f for

  int unsigned errors, sent_items, counted_items, cycle_count;
  int unsigned results_seen, done_seen, invalid_seen, capped_seen, cfg_phases;
  bit          quiet_run;

  // round(phi * w), half up; w is never negative
  function automatic longint phi_width(longint w);
    return (w * PhiQ16 + 32768) >>> 16;
  endfunction

  function automatic longint mid_of();
    return (br_lo + br_hi) >>> 1;
  endfunction

  function automatic gsm_res_t pack_result(logic kind, longint point, longint best,
                                           logic [1:0] st);
    gsm_res_t res;
    res.kind       = kind;
    res.point      = point[31:0];
    res.best_value = best[31:0];
    res.status     = st;
    res.iterations = iter_cnt;
    return res;
  endfunction

  // Status uses the max_iter value in force when the search ends
  function automatic logic [1:0] end_status();
    if (iter_cnt >= cur_max_iter && (br_hi - br_lo) > tol_last) return STATUS_MAX_ITER;
    return STATUS_OK;
  endfunction

  // Width test, then one reduction toward the smaller value, a final probe, or the end
  function automatic gsm_res_t narrow_bracket();
    longint m, am;
    if (iter_cnt < cur_max_iter) begin
      m  = mid_of();
      am = (m < 0) ? -m : m;
      tol_last = longint'(cur_abs_tol) + ((am * longint'(cur_rel_tol)) >>> 16);
      if (br_hi - br_lo > tol_last) begin
        iter_cnt = iter_cnt + IterW'(1);
        if (f_c < f_d) begin
          br_hi = pt_d;
          pt_d  = pt_c;
          f_d   = f_c;
          pt_c  = br_hi - phi_width(br_hi - br_lo);
          ph    = PH_NEW_LEFT;
          return pack_result(KIND_PROBE, pt_c, 0, STATUS_OK);
        end else begin
          br_lo = pt_c;
          pt_c  = pt_d;
          f_c   = f_d;
          pt_d  = br_lo + phi_width(br_hi - br_lo);
          ph    = PH_NEW_RIGHT;
          return pack_result(KIND_PROBE, pt_d, 0, STATUS_OK);
        end
      end
    end
    if (want_final) begin
      ph = PH_FINAL;
      return pack_result(KIND_PROBE, mid_of(), 0, STATUS_OK);
    end
    ph = PH_IDLE;
    return pack_result(KIND_DONE, mid_of(), 0, end_status());
  endfunction

  // Returns 1 when the request produces a result
  function automatic bit predict_search_step(input gsm_req_t r, output gsm_res_t res);
    longint a, b, fv;
    a   = longint'($signed(r.lower));
    b   = longint'($signed(r.upper));
    fv  = longint'($signed(r.func_value));
    res = '0;
    if (r.command == CMD_START) begin
      iter_cnt   = '0;
      tol_last   = 0;
      want_final = r.want_value;
      if (a >= b) begin
        ph  = PH_IDLE;
        res = pack_result(KIND_DONE, 0, 0, STATUS_INVALID);
        return 1'b1;
      end
      br_lo = a;
      br_hi = b;
      pt_c  = b - phi_width(b - a);
      pt_d  = a + phi_width(b - a);
      f_c   = 0;
      f_d   = 0;
      ph    = PH_FIRST;
      res   = pack_result(KIND_PROBE, pt_c, 0, STATUS_OK);
      return 1'b1;
    end
    case (ph)
      PH_FIRST: begin
        f_c = fv;
        ph  = PH_SECOND;
        res = pack_result(KIND_PROBE, pt_d, 0, STATUS_OK);
        return 1'b1;
      end
      PH_SECOND, PH_NEW_RIGHT: begin
        f_d = fv;
        res = narrow_bracket();
        return 1'b1;
      end
      PH_NEW_LEFT: begin
        f_c = fv;
        res = narrow_bracket();
        return 1'b1;
      end
      PH_FINAL: begin
        ph  = PH_IDLE;
        res = pack_result(KIND_DONE, mid_of(), fv, end_status());
        return 1'b1;
      end
      default: return 1'b0;  // value with no search running
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Present one request, wait for acceptance, then predict. A typed result,
  // when given, replaces the predicted one as the expectation.
  task automatic send(input gsm_req_t r, input bit typed, input gsm_res_t typed_res);
    gsm_res_t res;
    while (!quiet_run && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
    if (predict_search_step(r, res)) begin
      expected_results.push_back(typed ? typed_res : res);
      counted_items++;
      if (res.kind == KIND_PROBE) last_probe = res.point;
    end
  endtask

  // Let everything in flight come out, and give a request that was swallowed
  // without a result time to pass through
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ABS_TOL:  cur_abs_tol  = data[AbsTolW-1:0];
      CFG_REL_TOL:  cur_rel_tol  = data[RelTolW-1:0];
      CFG_MAX_ITER: cur_max_iter = data[IterW-1:0];
      default: ;
    endcase
  endtask

  function automatic gsm_req_t random_req();
    gsm_req_t r;
    r.command    = 1'($urandom_range(1));
    r.lower      = $urandom;
    r.upper      = $urandom;
    r.want_value = 1'($urandom_range(1));
    r.func_value = $urandom;
    return r;
  endfunction

  // One well-formed search: a start with a valid bracket, then values until
  // the predictor is idle again. Most runs answer with |x - target| so the
  // bracket homes in; the rest use random values. Now and then a stray start
  // drops the search.
  task automatic search_round();
    gsm_req_t r;
    gsm_res_t none;
    longint w, lo, target, gap_abs;
    longint unsigned span, rnd;
    bit shaped;
    none = '0;
    case ($urandom_range(2))
      0:       w = longint'($urandom_range(24, 1));
      1:       w = longint'($urandom_range(32'd1 << 22, 25));
      default: w = longint'($urandom_range(32'hffff_ffff, 1));
    endcase
    span = 64'd4294967296 - longint'(w);
    rnd  = {$urandom, $urandom};
    lo   = longint'(rnd % span) - 64'sd2147483648;
    r            = random_req();
    r.command    = CMD_START;
    r.lower      = lo[31:0];
    r.upper      = 32'(lo + w);
    rnd          = {$urandom, $urandom};
    target       = lo + longint'(rnd % longint'(w + 1));
    shaped       = $urandom_range(99) < 60;
    send(r, 1'b0, none);
    while (ph != PH_IDLE) begin
      r = random_req();
      if ($urandom_range(99) < 4) begin
        r.command = CMD_START;
        shaped    = 1'b0;
      end else begin
        r.command = CMD_VALUE;
        if (shaped) begin
          gap_abs = longint'(last_probe) - target;
          if (gap_abs < 0) gap_abs = -gap_abs;
          if (gap_abs > longint'(QMax)) gap_abs = longint'(QMax);
          r.func_value = gap_abs[31:0];
        end
      end
      send(r, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e           kind;
    gsm_req_t            req;
    logic [CfgIdxW-1:0]  cidx;
    logic [CfgDataW-1:0] cdata;
    bit                  typed;
    gsm_res_t            want_res;
  } dir_row_t;

  dir_row_t dir_table[$];

  function automatic dir_row_t req_row(logic cmd, int lo, int up, logic want, int fv);
    dir_row_t row;
    row.kind           = ROW_REQ;
    row.req.command    = cmd;
    row.req.lower      = lo;
    row.req.upper      = up;
    row.req.want_value = want;
    row.req.func_value = fv;
    row.cidx           = '0;
    row.cdata          = '0;
    row.typed          = 1'b0;
    row.want_res       = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t row, logic kind, int point, int best,
                                         logic [1:0] st, logic [IterW-1:0] it);
    row.typed               = 1'b1;
    row.want_res.kind       = kind;
    row.want_res.point      = point;
    row.want_res.best_value = best;
    row.want_res.status     = st;
    row.want_res.iterations = it;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    dir_row_t row;
    row       = req_row(CMD_VALUE, 0, 0, 1'b0, 0);
    row.kind  = ROW_CFG;
    row.cidx  = idx;
    row.cdata = data;
    return row;
  endfunction

  initial begin
    // value with nothing running: swallowed
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 0));
    // empty and reversed brackets finish at once as invalid
    dir_table.push_back(typed_row(req_row(CMD_START, 5, 5, 1'b0, 0),
                                  KIND_DONE, 0, 0, STATUS_INVALID, '0));
    dir_table.push_back(typed_row(req_row(CMD_START, QMax, QMin, 1'b1, QMax),
                                  KIND_DONE, 0, 0, STATUS_INVALID, '0));
    // short search with extreme values, then dropped by a full-range start
    dir_table.push_back(req_row(CMD_START, 0, 40, 1'b1, 0));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, QMin));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, QMax));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 0));
    dir_table.push_back(req_row(CMD_START, QMin, QMax, 1'b0, -1));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 100));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, -100));
    // zero iteration cap: both probes, then out with the cap status
    dir_table.push_back(cfg_row(CFG_MAX_ITER, CfgDataW'(0)));
    dir_table.push_back(req_row(CMD_START, -8, 8, 1'b0, 0));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 3));
    dir_table.push_back(typed_row(req_row(CMD_VALUE, 0, 0, 1'b0, 3),
                                  KIND_DONE, 0, 0, STATUS_MAX_ITER, '0));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 7));
    // same, with a final probe at the midpoint
    dir_table.push_back(req_row(CMD_START, -8, 8, 1'b1, 0));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, 1));
    dir_table.push_back(typed_row(req_row(CMD_VALUE, 0, 0, 1'b0, 2),
                                  KIND_PROBE, 0, 0, STATUS_OK, '0));
    dir_table.push_back(typed_row(req_row(CMD_VALUE, 0, 0, 1'b0, QMin),
                                  KIND_DONE, 0, QMin, STATUS_MAX_ITER, '0));
    // all registers at their top values
    dir_table.push_back(cfg_row(CFG_MAX_ITER, CfgDataW'(1023)));
    dir_table.push_back(cfg_row(CFG_ABS_TOL, CfgDataW'(31'h7fff_ffff)));
    dir_table.push_back(cfg_row(CFG_REL_TOL, CfgDataW'(65535)));
    dir_table.push_back(req_row(CMD_START, QMin, QMax, 1'b1, 0));
    // bracket already inside tolerance: done after the two probes
    dir_table.push_back(req_row(CMD_START, 0, 100, 1'b0, 0));
    dir_table.push_back(req_row(CMD_VALUE, 0, 0, 1'b0, -5));
    dir_table.push_back(typed_row(req_row(CMD_VALUE, 0, 0, 1'b0, 9),
                                  KIND_DONE, 50, 0, STATUS_OK, '0));
  end

  // ---------------------------------------------------------------------
  // Result side: random stall, checker, watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk_i) out_stall_i <= !quiet_run && ($urandom_range(99) < 26);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch %s: got %h expected %h (result %0d)",
               $realtime, what, got, want_v, results_seen);
  endtask

  always @(posedge clk_i) begin : check_results
    gsm_res_t want_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_res_o.kind == KIND_DONE) done_seen++;
      if (out_res_o.kind == KIND_DONE && out_res_o.status == STATUS_INVALID) invalid_seen++;
      if (out_res_o.kind == KIND_DONE && out_res_o.status == STATUS_MAX_ITER) capped_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result, point", out_res_o.point, '0);
      end else begin
        want_r = expected_results.pop_front();
        if (out_res_o.kind != want_r.kind)
          report_mismatch("kind", 32'(out_res_o.kind), 32'(want_r.kind));
        if (out_res_o.point != want_r.point)
          report_mismatch("point", out_res_o.point, want_r.point);
        if (out_res_o.best_value != want_r.best_value)
          report_mismatch("best_value", out_res_o.best_value, want_r.best_value);
        if (out_res_o.status != want_r.status)
          report_mismatch("status", 32'(out_res_o.status), 32'(want_r.status));
        if (out_res_o.iterations != want_r.iterations)
          report_mismatch("iterations", 32'(out_res_o.iterations), 32'(want_r.iterations));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    gsm_req_t r;
    gsm_res_t none;
    int unsigned goal, p, phase_end;
    logic [AbsTolW-1:0] abs_v;
    logic [RelTolW-1:0] rel_v;
    logic [IterW-1:0]   it_v;
    bit held;
    none = '0;
    held = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) write_reg(dir_table[i].cidx, dir_table[i].cdata);
      else send(dir_table[i].req, dir_table[i].typed, dir_table[i].want_res);
    end

    // Random phases, each with its own register setting. The first one has
    // zero tolerance so small brackets stall and end on the iteration cap.
    goal = counted_items + RandItems;
    for (p = 0; counted_items < goal; p++) begin
      if (p == 0) begin
        abs_v = '0;
        rel_v = '0;
        it_v  = IterW'(20);
      end else begin
        case ($urandom_range(3))
          0:       abs_v = '0;
          1:       abs_v = '1;
          2:       abs_v = AbsTolW'($urandom_range(255));
          default: abs_v = AbsTolW'($urandom);
        endcase
        case ($urandom_range(3))
          0:       rel_v = '0;
          1:       rel_v = '1;
          2:       rel_v = RelTolW'($urandom_range(31));
          default: rel_v = RelTolW'($urandom);
        endcase
        case ($urandom_range(3))
          0:       it_v = '0;
          1:       it_v = IterW'(1);
          2:       it_v = IterW'($urandom_range(40, 2));
          default: it_v = '1;
        endcase
        // a full cap with zero tolerance would spin on a stalled bracket
        if (it_v == '1 && abs_v == '0) abs_v = AbsTolW'(1);
      end
      write_reg(CFG_ABS_TOL, CfgDataW'(abs_v));
      write_reg(CFG_REL_TOL, CfgDataW'(rel_v));
      write_reg(CFG_MAX_ITER, CfgDataW'(it_v));
      cfg_phases++;
      quiet_run = (p == 2);
      phase_end = counted_items + 140;
      while (counted_items < phase_end && counted_items < goal) begin
        // once, hold the sender until the block has handed back everything
        if (!held && counted_items >= goal - RandItems / 2) begin
          held = 1'b1;
          in_valid_i <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        case ($urandom_range(19))
          0: begin  // value with no search running
            r = random_req();
            r.command = CMD_VALUE;
            send(r, 1'b0, none);
          end
          1: begin  // reversed or empty bracket
            r = random_req();
            r.command = CMD_START;
            r.upper   = ($urandom_range(1) != 0) ? r.lower : r.lower - 32'sd1 - 32'(r.upper[7:0]);
            if ($signed(r.upper) > $signed(r.lower)) r.upper = r.lower;
            send(r, 1'b0, none);
          end
          default: search_round();
        endcase
      end
    end
    quiet_run = 1'b0;

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d requests over %0d register settings; checked %0d results",
             sent_items, cfg_phases + 1, results_seen);
    $display("%0d searches finished: %0d invalid brackets, %0d stopped by the iteration cap",
             done_seen, invalid_seen, capped_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
